### hw/rtl/ngga_pkg.sv
// Shared types, constants and helper functions for the GGA position parser.
package ngga_pkg;

   typedef enum logic [1:0] {
      ST_NOT_GGA   = 2'd0,
      ST_BAD_SUM   = 2'd1,
      ST_NO_CHANGE = 2'd2,
      ST_UPDATED   = 2'd3
   } status_type;

   localparam int RAW_W = 31;
   localparam logic [RAW_W-1:0] RAW_MAX = '1;
   localparam longint unsigned RAW_SPAN = 64'h8000_0000;  // 2^RAW_W
   localparam int POW_W = 24;

   localparam logic [2:0] HDR_LEN = 3'd6;
   localparam logic [2:0] FLD_LAT = 3'd2;
   localparam logic [2:0] FLD_NS = 3'd3;
   localparam logic [2:0] FLD_LON = 3'd4;
   localparam logic [2:0] FLD_EW = 3'd5;
   localparam logic [2:0] FLD_FIX = 3'd6;
   localparam logic [2:0] FLD_LAST = 3'd7;

   // number flag bits: stop, decimal point seen, then a 3-bit fraction count
   localparam int NF_STOP = 0;
   localparam int NF_DOT = 1;
   localparam int NF_FIX_STOP = 1;

   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_STAR = 8'h2A;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_DOT = 8'h2E;
   localparam logic [7:0] CH_ZERO = 8'h30;
   localparam logic [7:0] CH_NINE = 8'h39;
   localparam logic [7:0] CH_UP_A = 8'h41;
   localparam logic [7:0] CH_UP_F = 8'h46;
   localparam logic [7:0] CH_LO_A = 8'h61;
   localparam logic [7:0] CH_LO_F = 8'h66;
   localparam logic [7:0] CH_G = 8'h47;
   localparam logic [7:0] CH_P = 8'h50;
   localparam logic [7:0] CH_N = 8'h4E;
   localparam logic [7:0] CH_S = 8'h53;
   localparam logic [7:0] CH_W = 8'h57;

   // conversion pipeline
   localparam int CONV_STAGES = 7;
   localparam longint unsigned DDMM_SCALE = 100;
   localparam int E7_DIGITS = 7;
   localparam int DEG_CAP = 180;
   localparam int E7_SCALE = 10000000;
   localparam int MIN_PER_DEG = 60;
   localparam int X_W = 30;
   localparam int RECIP_W = 25;
   localparam logic [RECIP_W-1:0] DIV60_RECIP = 25'd17895697;  // floor(2^30 / 60)

   typedef struct packed {
      status_type       status;
      logic [7:0]       fix;
      logic             update;
      logic [RAW_W-1:0] raw_lat;
      logic [RAW_W-1:0] raw_lon;
      logic             south;
      logic             west;
   } snap_type;

   typedef struct packed {
      logic       valid;
      status_type status;
      logic [7:0] fix;
      logic       update;
   } side_type;

   function automatic logic [POW_W-1:0] pow10(input logic [2:0] k);
      logic [POW_W-1:0] r;
      unique case (k)
         3'd0: r = 24'd1;
         3'd1: r = 24'd10;
         3'd2: r = 24'd100;
         3'd3: r = 24'd1000;
         3'd4: r = 24'd10000;
         3'd5: r = 24'd100000;
         3'd6: r = 24'd1000000;
         3'd7: r = 24'd10000000;
         default: r = 24'd1;
      endcase
      return r;
   endfunction

   function automatic logic [7:0] hdr_char(input logic [2:0] pos);
      logic [7:0] c;
      unique case (pos)
         3'd0: c = CH_DOLLAR;
         3'd1: c = CH_G;
         3'd2: c = CH_P;
         3'd3: c = CH_G;
         3'd4: c = CH_G;
         3'd5: c = CH_UP_A;
         default: c = 8'h00;
      endcase
      return c;
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   // {valid, value}
   function automatic logic [4:0] hex_nibble(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (is_digit(c)) begin
         r = {1'b1, c[3:0]};
      end else if ((c >= CH_UP_A && c <= CH_UP_F) || (c >= CH_LO_A && c <= CH_LO_F)) begin
         r = {1'b1, 4'(c[3:0] + 4'd9)};
      end
      return r;
   endfunction

endpackage

### hw/rtl/ngga_parser.sv
// Per-byte sentence state: header match, checksum, field decode and fix commit.
module ngga_parser #(
   parameter int FRACTION_DIGITS = 5
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               fire,
   input  logic [7:0]         char_byte,
   input  logic               sentence_end,
   output ngga_pkg::snap_type snap
);

   localparam logic [2:0] FD3 = 3'(FRACTION_DIGITS);

   typedef struct packed {
      logic [ngga_pkg::RAW_W-1:0] raw;
      logic [4:0]                 flags;
   } coord_type;

   function automatic coord_type coord_step(input logic [ngga_pkg::RAW_W-1:0] raw,
                                            input logic [4:0] nf, input logic [7:0] ch);
      coord_type  r;
      logic [2:0] fc;
      logic [35:0] v;
      logic       take;
      r.raw = raw;
      r.flags = nf;
      fc = nf[4:2];
      v = '0;
      take = 1'b0;
      if (!nf[ngga_pkg::NF_STOP]) begin
         if (ngga_pkg::is_digit(ch)) begin
            if (!nf[ngga_pkg::NF_DOT]) begin
               v = 36'(raw) * 36'(10) + 36'(ch[3:0]) * 36'(ngga_pkg::pow10(FD3));
               take = 1'b1;
            end else if (fc < FD3) begin
               fc = fc + 3'd1;
               r.flags[4:2] = fc;
               v = 36'(raw) + 36'(ch[3:0]) * 36'(ngga_pkg::pow10(3'(FD3 - fc)));
               take = 1'b1;
            end
         end else if (ch == ngga_pkg::CH_DOT && !nf[ngga_pkg::NF_DOT]) begin
            r.flags[ngga_pkg::NF_DOT] = 1'b1;
         end else begin
            r.flags[ngga_pkg::NF_STOP] = 1'b1;
         end
         if (take) begin
            r.raw = (v > 36'(ngga_pkg::RAW_MAX)) ? ngga_pkg::RAW_MAX : ngga_pkg::RAW_W'(v);
         end
      end
      return r;
   endfunction

   logic [2:0]                 hdr_pos_ff, hdr_pos_in;
   logic                       hdr_match_ff, hdr_match_in;
   logic [7:0]                 xor_ff, xor_in;
   logic                       after_star_ff, after_star_in;
   logic [1:0]                 hex_cnt_ff, hex_cnt_in;
   logic [7:0]                 rx_sum_ff, rx_sum_in;
   logic                       hex_bad_ff, hex_bad_in;
   logic [2:0]                 field_ff, field_in;
   logic [4:0]                 nflags_ff, nflags_in;
   logic [ngga_pkg::RAW_W-1:0] raw_lat_ff, raw_lat_in;
   logic [ngga_pkg::RAW_W-1:0] raw_lon_ff, raw_lon_in;
   logic                       south_ff, south_in;
   logic                       west_ff, west_in;
   logic [7:0]                 fix_acc_ff, fix_acc_in;
   logic                       fix_seen_ff, fix_seen_in;
   logic [7:0]                 stored_fix_ff, stored_fix_in;

   coord_type           cstep;
   logic [4:0]          hex_val;
   logic [7:0]          acc0;
   logic [7:0]          fix_new;
   logic                sum_ok;
   logic                update;
   ngga_pkg::status_type status;

   // one shared coordinate datapath, fed from whichever coordinate field is open
   assign cstep = coord_step((field_ff == ngga_pkg::FLD_LON) ? raw_lon_ff : raw_lat_ff,
                             nflags_ff, char_byte);
   assign hex_val = ngga_pkg::hex_nibble(char_byte);
   assign acc0 = nflags_ff[ngga_pkg::NF_STOP] ? fix_acc_ff : 8'd0;

   always_comb begin
      hdr_pos_in = hdr_pos_ff;
      hdr_match_in = hdr_match_ff;
      xor_in = xor_ff;
      after_star_in = after_star_ff;
      hex_cnt_in = hex_cnt_ff;
      rx_sum_in = rx_sum_ff;
      hex_bad_in = hex_bad_ff;
      field_in = field_ff;
      nflags_in = nflags_ff;
      raw_lat_in = raw_lat_ff;
      raw_lon_in = raw_lon_ff;
      south_in = south_ff;
      west_in = west_ff;
      fix_acc_in = fix_acc_ff;
      fix_seen_in = fix_seen_ff;

      if (hdr_pos_ff < ngga_pkg::HDR_LEN) begin
         if (!(char_byte == ngga_pkg::hdr_char(hdr_pos_ff) ||
               (hdr_pos_ff == 3'd2 && char_byte == ngga_pkg::CH_N))) begin
            hdr_match_in = 1'b0;
         end
         hdr_pos_in = hdr_pos_ff + 3'd1;
      end

      if (hdr_pos_ff != 3'd0) begin
         if (!after_star_ff) begin
            if (char_byte == ngga_pkg::CH_STAR) begin
               after_star_in = 1'b1;
            end else begin
               xor_in = xor_ff ^ char_byte;
               if (char_byte == ngga_pkg::CH_COMMA) begin
                  if (field_ff != ngga_pkg::FLD_LAST) field_in = field_ff + 3'd1;
                  nflags_in = '0;
               end else begin
                  unique case (field_ff)
                     ngga_pkg::FLD_LAT: begin
                        raw_lat_in = cstep.raw;
                        nflags_in = cstep.flags;
                     end
                     ngga_pkg::FLD_LON: begin
                        raw_lon_in = cstep.raw;
                        nflags_in = cstep.flags;
                     end
                     ngga_pkg::FLD_NS: begin
                        if (!nflags_ff[ngga_pkg::NF_STOP]) begin
                           nflags_in[ngga_pkg::NF_STOP] = 1'b1;
                           south_in = (char_byte == ngga_pkg::CH_S);
                        end
                     end
                     ngga_pkg::FLD_EW: begin
                        if (!nflags_ff[ngga_pkg::NF_STOP]) begin
                           nflags_in[ngga_pkg::NF_STOP] = 1'b1;
                           west_in = (char_byte == ngga_pkg::CH_W);
                        end
                     end
                     ngga_pkg::FLD_FIX: begin
                        // first byte of the field restarts the value, 8-bit wrap
                        nflags_in[ngga_pkg::NF_STOP] = 1'b1;
                        if (!nflags_ff[ngga_pkg::NF_STOP]) fix_seen_in = 1'b1;
                        if (nflags_ff[ngga_pkg::NF_FIX_STOP]) begin
                           fix_acc_in = fix_acc_ff;
                        end else if (ngga_pkg::is_digit(char_byte)) begin
                           fix_acc_in = 8'(12'(acc0) * 12'(10) + 12'(char_byte[3:0]));
                        end else begin
                           fix_acc_in = acc0;
                           nflags_in[ngga_pkg::NF_FIX_STOP] = 1'b1;
                        end
                     end
                     default: ;
                  endcase
               end
            end
         end else if (hex_cnt_ff < 2'd2) begin
            if (!hex_val[4]) hex_bad_in = 1'b1;
            else rx_sum_in = {rx_sum_ff[3:0], hex_val[3:0]};
            hex_cnt_in = hex_cnt_ff + 2'd1;
         end
      end
   end

   // end-of-sentence verdict, on the state after this beat
   always_comb begin
      sum_ok = after_star_in && (hex_cnt_in == 2'd2) && !hex_bad_in && (rx_sum_in == xor_in);
      fix_new = fix_seen_in ? fix_acc_in : stored_fix_ff;
      update = 1'b0;
      stored_fix_in = stored_fix_ff;
      if (hdr_pos_in < ngga_pkg::HDR_LEN || !hdr_match_in) begin
         status = ngga_pkg::ST_NOT_GGA;
      end else if (!sum_ok) begin
         status = ngga_pkg::ST_BAD_SUM;
      end else begin
         stored_fix_in = fix_new;
         update = (fix_new != 8'd0) && (raw_lat_in != '0) && (raw_lon_in != '0);
         status = update ? ngga_pkg::ST_UPDATED : ngga_pkg::ST_NO_CHANGE;
      end
   end

   assign snap.status = status;
   assign snap.fix = stored_fix_in;
   assign snap.update = update;
   assign snap.raw_lat = raw_lat_in;
   assign snap.raw_lon = raw_lon_in;
   assign snap.south = south_in;
   assign snap.west = west_in;

   always_ff @(posedge clock) begin
      if (reset || (fire && sentence_end)) begin
         hdr_pos_ff <= 3'd0;
         hdr_match_ff <= 1'b1;
         xor_ff <= 8'd0;
         after_star_ff <= 1'b0;
         hex_cnt_ff <= 2'd0;
         rx_sum_ff <= 8'd0;
         hex_bad_ff <= 1'b0;
         field_ff <= 3'd0;
         nflags_ff <= 5'd0;
         raw_lat_ff <= '0;
         raw_lon_ff <= '0;
         south_ff <= 1'b0;
         west_ff <= 1'b0;
         fix_acc_ff <= 8'd0;
         fix_seen_ff <= 1'b0;
      end else if (fire) begin
         hdr_pos_ff <= hdr_pos_in;
         hdr_match_ff <= hdr_match_in;
         xor_ff <= xor_in;
         after_star_ff <= after_star_in;
         hex_cnt_ff <= hex_cnt_in;
         rx_sum_ff <= rx_sum_in;
         hex_bad_ff <= hex_bad_in;
         field_ff <= field_in;
         nflags_ff <= nflags_in;
         raw_lat_ff <= raw_lat_in;
         raw_lon_ff <= raw_lon_in;
         south_ff <= south_in;
         west_ff <= west_in;
         fix_acc_ff <= fix_acc_in;
         fix_seen_ff <= fix_seen_in;
      end
      if (reset) begin
         stored_fix_ff <= 8'd0;
      end else if (fire && sentence_end) begin
         stored_fix_ff <= stored_fix_in;
      end
   end

endmodule

### hw/rtl/ngga_to_e7.sv
// Pipelined DDMM.MMMMM to signed 1e-7 degree conversion with saturation.
module ngga_to_e7 #(
   parameter int FRACTION_DIGITS = 5,
   parameter int LIMIT_E7 = 900000000
) (
   input  logic                       clock,
   input  logic                       enable,
   input  logic [ngga_pkg::RAW_W-1:0] raw,
   input  logic                       neg,
   output logic signed [31:0]         e7
);

   localparam int RAW_W = ngga_pkg::RAW_W;
   localparam longint unsigned UNIT = 64'(ngga_pkg::pow10(3'(FRACTION_DIGITS)));
   localparam longint unsigned DIV_DEG = ngga_pkg::DDMM_SCALE * UNIT;
   localparam longint unsigned RECIP = ngga_pkg::RAW_SPAN / DIV_DEG;
   localparam longint unsigned MIN_MUL =
      64'(ngga_pkg::pow10(3'(ngga_pkg::E7_DIGITS - FRACTION_DIGITS)));
   localparam int QW = $clog2(RECIP + 1);
   localparam int RW = $clog2(DIV_DEG);
   localparam int PW = RAW_W + QW;
   localparam int XW = ngga_pkg::X_W;
   localparam int XPW = XW + ngga_pkg::RECIP_W;
   localparam int YW = ngga_pkg::RECIP_W;

   logic [RAW_W-1:0] raw0_ff, raw1_ff, raw2_ff;
   logic             neg0_ff, neg1_ff, neg2_ff, neg3_ff, neg4_ff, neg5_ff, neg6_ff;
   logic [QW-1:0]    qe1_ff, qe2_ff, q3_ff;
   logic [RAW_W-1:0] prod2_ff;
   logic [RW-1:0]    rem3_ff;
   logic [XW-1:0]    x4_ff, x5_ff;
   logic [7:0]       deg4_ff, deg5_ff;
   logic             sat4_ff, sat5_ff, sat6_ff;
   logic [YW-1:0]    ye5_ff, y6_ff;
   logic [30:0]      dp6_ff;

   logic [PW-1:0]    p1;
   logic [RAW_W-1:0] diff3;
   logic             ge3;
   logic [XPW-1:0]   p5;
   logic [XW-1:0]    r6;
   logic [31:0]      mag;
   logic [31:0]      mag_c;

   // degrees = raw / (100 * 10^FD): reciprocal estimate, low by at most one
   assign p1 = PW'(raw0_ff) * PW'(RECIP);
   assign diff3 = raw2_ff - prod2_ff;
   assign ge3 = diff3 >= RAW_W'(DIV_DEG);
   // minutes scaled to 1e-7 degree: (rem * 10^(7-FD)) / 60
   assign p5 = XPW'(x4_ff) * XPW'(ngga_pkg::DIV60_RECIP);
   assign r6 = x5_ff - XW'(XW'(ye5_ff) * XW'(ngga_pkg::MIN_PER_DEG));

   assign mag = 32'(dp6_ff) + 32'(y6_ff);
   assign mag_c = (sat6_ff || mag > 32'(LIMIT_E7)) ? 32'(LIMIT_E7) : mag;
   assign e7 = neg6_ff ? -$signed(mag_c) : $signed(mag_c);

   always_ff @(posedge clock) begin
      if (enable) begin
         raw0_ff <= raw;
         neg0_ff <= neg;

         qe1_ff <= p1[PW-1:RAW_W];
         raw1_ff <= raw0_ff;
         neg1_ff <= neg0_ff;

         prod2_ff <= RAW_W'(RAW_W'(qe1_ff) * RAW_W'(DIV_DEG));
         qe2_ff <= qe1_ff;
         raw2_ff <= raw1_ff;
         neg2_ff <= neg1_ff;

         q3_ff <= qe2_ff + QW'(ge3);
         rem3_ff <= RW'(ge3 ? diff3 - RAW_W'(DIV_DEG) : diff3);
         neg3_ff <= neg2_ff;

         x4_ff <= XW'(XW'(rem3_ff) * XW'(MIN_MUL));
         deg4_ff <= 8'(q3_ff);
         sat4_ff <= 32'(q3_ff) > 32'(ngga_pkg::DEG_CAP);
         neg4_ff <= neg3_ff;

         ye5_ff <= p5[XPW-1:XW];
         x5_ff <= x4_ff;
         deg5_ff <= deg4_ff;
         sat5_ff <= sat4_ff;
         neg5_ff <= neg4_ff;

         y6_ff <= ye5_ff + YW'(r6 >= XW'(ngga_pkg::MIN_PER_DEG));
         dp6_ff <= 31'(31'(deg5_ff) * 31'(ngga_pkg::E7_SCALE));
         sat6_ff <= sat5_ff;
         neg6_ff <= neg5_ff;
      end
   end

endmodule

### hw/rtl/nmea_gga_position_parser.sv
// NMEA GGA parser top level: input register, byte parser, conversion pipeline, result register.
// Takes one NMEA byte per clock on req_ and gives one result beat on rsp_ for
// each sentence, in sentence order. A byte is registered on acceptance and parsed
// from the input register; on the last byte of a sentence the verdict and raw
// coordinates enter a 7-stage fixed-point conversion pipeline (two reciprocal
// multiplies for the divides by 100*10^FRACTION_DIGITS and by 60), followed by
// the result register. Bytes that end no sentence keep flowing while a result is
// stalled; a last byte waits in the input register until the pipeline can move.
// Stored latitude, longitude and fix are those after each sentence's commit and
// are shown with every result.
module nmea_gga_position_parser #(
   parameter int FRACTION_DIGITS = 5
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [7:0]         req_char_byte,
   input  logic               req_sentence_end,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic signed [30:0] rsp_latitude_e7,
   output logic signed [31:0] rsp_longitude_e7,
   output logic [7:0]         rsp_fix_quality
);

   localparam int LAST = ngga_pkg::CONV_STAGES - 1;

   logic                  in_valid_ff;
   logic [7:0]            char_ff;
   logic                  end_ff;
   logic                  adv;
   logic                  fire;
   logic                  ready0;
   ngga_pkg::snap_type    snap;
   ngga_pkg::side_type    side_ff [ngga_pkg::CONV_STAGES];
   logic signed [31:0]    lat_e7;
   logic signed [31:0]    lon_e7;
   logic                  rsp_valid_ff;
   ngga_pkg::status_type  rsp_status_ff;
   logic [7:0]            rsp_fix_ff;
   logic signed [30:0]    stored_lat_ff;
   logic signed [31:0]    stored_lon_ff;

   assign adv = !rsp_valid_ff || !rsp_stall;
   assign fire = in_valid_ff && (!end_ff || adv);
   assign ready0 = !in_valid_ff || fire;
   assign req_stall = !ready0;

   ngga_parser #(
      .FRACTION_DIGITS(FRACTION_DIGITS)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .fire        (fire),
      .char_byte   (char_ff),
      .sentence_end(end_ff),
      .snap        (snap)
   );

   ngga_to_e7 #(
      .FRACTION_DIGITS(FRACTION_DIGITS),
      .LIMIT_E7       (900000000)
   ) u_lat (
      .clock (clock),
      .enable(adv),
      .raw   (snap.raw_lat),
      .neg   (snap.south),
      .e7    (lat_e7)
   );

   ngga_to_e7 #(
      .FRACTION_DIGITS(FRACTION_DIGITS),
      .LIMIT_E7       (1800000000)
   ) u_lon (
      .clock (clock),
      .enable(adv),
      .raw   (snap.raw_lon),
      .neg   (snap.west),
      .e7    (lon_e7)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (ready0) begin
         in_valid_ff <= req_valid;
      end
      if (ready0 && req_valid) begin
         char_ff <= req_char_byte;
         end_ff <= req_sentence_end;
      end
   end

   // sideband travels alongside the conversion stages
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < ngga_pkg::CONV_STAGES; i++) begin
            side_ff[i] <= '0;
         end
      end else if (adv) begin
         side_ff[0].valid <= fire && end_ff;
         side_ff[0].status <= snap.status;
         side_ff[0].fix <= snap.fix;
         side_ff[0].update <= snap.update;
         for (int i = 1; i < ngga_pkg::CONV_STAGES; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         stored_lat_ff <= '0;
         stored_lon_ff <= '0;
      end else if (adv) begin
         rsp_valid_ff <= side_ff[LAST].valid;
         if (side_ff[LAST].valid && side_ff[LAST].update) begin
            stored_lat_ff <= 31'(lat_e7);
            stored_lon_ff <= lon_e7;
         end
      end
      if (adv && side_ff[LAST].valid) begin
         rsp_status_ff <= side_ff[LAST].status;
         rsp_fix_ff <= side_ff[LAST].fix;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_fix_quality = rsp_fix_ff;
   assign rsp_latitude_e7 = stored_lat_ff;
   assign rsp_longitude_e7 = stored_lon_ff;

`ifndef SYNTHESIS
   a_update_has_fix: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff == ngga_pkg::ST_UPDATED |-> rsp_fix_ff != 8'd0)
      else $error("updated position reported with zero fix");

   a_lat_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> stored_lat_ff <= 900000000 && stored_lat_ff >= -900000000)
      else $error("stored latitude beyond 90 degrees");

   a_pos_change_on_update: assert property (@(posedge clock) disable iff (reset)
      !$stable(stored_lat_ff) |-> rsp_valid_ff && rsp_status_ff == ngga_pkg::ST_UPDATED)
      else $error("stored latitude changed without an updated result");

   a_end_beat_held: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && end_ff && !adv |=> in_valid_ff && end_ff)
      else $error("sentence end beat dropped while pipeline held");
`endif

endmodule
